// ===== rtl/core/id_coalescing_tx_queue_macros.svh =====
// ----------------------------------------------------------------------------
// id_coalescing_tx_queue_macros
// assertion helpers used by the coalescing transmit queue
// ----------------------------------------------------------------------------
`ifndef ID_COALESCING_TX_QUEUE_MACROS_SVH
`define ID_COALESCING_TX_QUEUE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ICQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ICQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/icq_pkg.sv =====
// ----------------------------------------------------------------------------
// icq_pkg
// types, codes and widths of the coalescing transmit queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package icq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int MAX_POPS            = 16;

    localparam int ID_W     = 29;
    localparam int LEN_W    = 4;
    localparam int DATA_W   = 64;
    localparam int AMOUNT_W = 16;
    localparam int FREE_W   = 7;
    localparam int FIELD_W  = 5;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 112;

    // result kinds
    localparam logic [1:0] KIND_ENQ_STATUS = 2'd0;
    localparam logic [1:0] KIND_FRAME      = 2'd1;
    localparam logic [1:0] KIND_SUMMARY    = 2'd2;

    // enqueue status codes
    localparam logic [1:0] STATUS_APPENDED = 2'd0;
    localparam logic [1:0] STATUS_REPLACED = 2'd1;
    localparam logic [1:0] STATUS_REJECTED = 2'd2;

    // command codes
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DRAIN   = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  frame_len;
        logic [DATA_W-1:0] data;
    } icq_entry_t;

    typedef struct packed {
        logic                cmd;
        logic [ID_W-1:0]     frame_id;
        logic [LEN_W-1:0]    frame_length;
        logic [DATA_W-1:0]   frame_data;
        logic [AMOUNT_W-1:0] drain_amount;
        logic [FREE_W-1:0]   fifo_free;
    } icq_item_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [1:0]         enqueue_status;
        logic [ID_W-1:0]    out_id;
        logic [LEN_W-1:0]   out_length;
        logic [DATA_W-1:0]  out_data;
        logic [FIELD_W-1:0] processed;
        logic [FIELD_W-1:0] occupancy;
        logic               drain_pending;
        logic               last;
    } icq_result_t;

endpackage

// ===== rtl/core/icq_entry_ram.sv =====
// ----------------------------------------------------------------------------
// icq_entry_ram
// queue entry storage, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icq_entry_ram #(
    parameter int DEPTH  = icq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int ADDR_W = $clog2(icq_pkg::DEFAULT_QUEUE_DEPTH)
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  icq_pkg::icq_entry_t wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output icq_pkg::icq_entry_t rd_data
);
    import icq_pkg::*;

    icq_entry_t mem [DEPTH];
    icq_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/icq_ctrl.sv =====
// ----------------------------------------------------------------------------
// icq_ctrl
// sequencer: identifier search, append, drain and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "id_coalescing_tx_queue_macros.svh"

module icq_ctrl #(
    parameter int QUEUE_DEPTH = icq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int PTR_W       = $clog2(icq_pkg::DEFAULT_QUEUE_DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  icq_pkg::icq_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output icq_pkg::icq_result_t out_result,
    output logic                 ram_wr_en,
    output logic [PTR_W-1:0]     ram_wr_addr,
    output icq_pkg::icq_entry_t  ram_wr_data,
    output logic                 ram_rd_en,
    output logic [PTR_W-1:0]     ram_rd_addr,
    input  icq_pkg::icq_entry_t  ram_rd_data
);
    import icq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_ENQ_RESULT,
        ST_POP,
        ST_SUMMARY
    } state_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic               flag_reg, flag_next;
    icq_entry_t         frame_reg, frame_next;
    logic [PTR_W-1:0]   search_idx_reg, search_idx_next;
    logic [CNT_W-1:0]   search_off_reg, search_off_next;
    logic [1:0]         status_reg, status_next;
    logic [CNT_W-1:0]   pops_left_reg, pops_left_next;
    logic [CNT_W-1:0]   done_reg, done_next;
    logic               out_valid_reg, out_valid_next;
    icq_result_t        out_reg, out_next;

    logic               slot_free;
    logic [CNT_W-1:0]   off_inc;
    logic [PTR_W-1:0]   search_idx_inc;
    logic [PTR_W-1:0]   rd_ptr_inc;
    logic [AMOUNT_W-1:0] occ_ext;
    logic [AMOUNT_W-1:0] free_ext;
    logic [AMOUNT_W-1:0] lim_amount;
    logic [AMOUNT_W-1:0] lim_free;
    logic [AMOUNT_W-1:0] lim_cap;
    logic [CNT_W-1:0]   drain_limit;
    logic [CNT_W+FIELD_W-1:0] occ_wide;
    logic [CNT_W+FIELD_W-1:0] done_wide;
    logic [FIELD_W-1:0] occ_field;
    logic [FIELD_W-1:0] done_field;

    assign slot_free      = !out_valid_reg || out_ready;
    assign off_inc        = search_off_reg + 1'b1;
    assign search_idx_inc = ptr_inc(search_idx_reg);
    assign rd_ptr_inc     = ptr_inc(rd_ptr_reg);

    // drain size: requested amount, queued count, downstream space, result cap
    assign occ_ext    = AMOUNT_W'(occ_reg);
    assign free_ext   = AMOUNT_W'(in_item.fifo_free);
    assign lim_amount = (in_item.drain_amount != '0 && in_item.drain_amount < occ_ext) ?
                        in_item.drain_amount : occ_ext;
    assign lim_free   = (free_ext < lim_amount) ? free_ext : lim_amount;
    assign lim_cap    = (AMOUNT_W'(MAX_POPS) < lim_free) ? AMOUNT_W'(MAX_POPS) : lim_free;
    assign drain_limit = lim_cap[CNT_W-1:0];

    // reported counts keep their low bits
    assign occ_wide   = {{FIELD_W{1'b0}}, occ_reg};
    assign done_wide  = {{FIELD_W{1'b0}}, done_reg};
    assign occ_field  = occ_wide[FIELD_W-1:0];
    assign done_field = done_wide[FIELD_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        occ_next        = occ_reg;
        flag_next       = flag_reg;
        frame_next      = frame_reg;
        search_idx_next = search_idx_reg;
        search_off_next = search_off_reg;
        status_next     = status_reg;
        pops_left_next  = pops_left_reg;
        done_next       = done_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = wr_ptr_reg;
        ram_wr_data     = frame_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = rd_ptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    frame_next.id        = in_item.frame_id;
                    frame_next.frame_len = in_item.frame_length;
                    frame_next.data      = in_item.frame_data;
                    if (in_item.cmd == CMD_ENQUEUE)
                    begin
                        if (occ_reg == '0)
                        begin
                            state_next = ST_DECIDE;
                        end
                        else
                        begin
                            ram_rd_en       = 1'b1;
                            ram_rd_addr     = rd_ptr_reg;
                            search_idx_next = rd_ptr_reg;
                            search_off_next = '0;
                            state_next      = ST_SEARCH;
                        end
                    end
                    else
                    begin
                        // counts settle now so every result of the drain reports them
                        occ_next       = occ_reg - drain_limit;
                        flag_next      = (occ_reg != drain_limit);
                        pops_left_next = drain_limit;
                        done_next      = '0;
                        if (drain_limit != '0)
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = rd_ptr_reg;
                            state_next  = ST_POP;
                        end
                        else
                        begin
                            state_next = ST_SUMMARY;
                        end
                    end
                end
            end

            ST_SEARCH:
            begin
                // ram_rd_data holds the entry at search_idx_reg
                if (ram_rd_data.id == frame_reg.id)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = search_idx_reg;
                    flag_next   = 1'b1;
                    status_next = STATUS_REPLACED;
                    state_next  = ST_ENQ_RESULT;
                end
                else if (off_inc < occ_reg)
                begin
                    ram_rd_en       = 1'b1;
                    ram_rd_addr     = search_idx_inc;
                    search_idx_next = search_idx_inc;
                    search_off_next = off_inc;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (occ_reg == CNT_FULL)
                begin
                    status_next = STATUS_REJECTED;
                end
                else
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = wr_ptr_reg;
                    wr_ptr_next = ptr_inc(wr_ptr_reg);
                    occ_next    = occ_reg + 1'b1;
                    flag_next   = 1'b1;
                    status_next = STATUS_APPENDED;
                end
                state_next = ST_ENQ_RESULT;
            end

            ST_ENQ_RESULT:
            begin
                if (slot_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next                = '0;
                    out_next.result_kind    = KIND_ENQ_STATUS;
                    out_next.enqueue_status = status_reg;
                    out_next.occupancy      = occ_field;
                    out_next.drain_pending  = flag_reg;
                    out_next.last           = 1'b1;
                    state_next              = ST_IDLE;
                end
            end

            ST_POP:
            begin
                if (slot_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next               = '0;
                    out_next.result_kind   = KIND_FRAME;
                    out_next.out_id        = ram_rd_data.id;
                    out_next.out_length    = ram_rd_data.frame_len;
                    out_next.out_data      = ram_rd_data.data;
                    out_next.occupancy     = occ_field;
                    out_next.drain_pending = flag_reg;
                    rd_ptr_next            = rd_ptr_inc;
                    done_next              = done_reg + 1'b1;
                    pops_left_next         = pops_left_reg - 1'b1;
                    if (pops_left_reg != CNT_W'(1))
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = rd_ptr_inc;
                    end
                    else
                    begin
                        state_next = ST_SUMMARY;
                    end
                end
            end

            ST_SUMMARY:
            begin
                if (slot_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next               = '0;
                    out_next.result_kind   = KIND_SUMMARY;
                    out_next.processed     = done_field;
                    out_next.occupancy     = occ_field;
                    out_next.drain_pending = flag_reg;
                    out_next.last          = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            occ_reg        <= '0;
            flag_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            search_off_reg <= '0;
            pops_left_reg  <= '0;
            done_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            occ_reg        <= occ_next;
            flag_reg       <= flag_next;
            out_valid_reg  <= out_valid_next;
            search_off_reg <= search_off_next;
            pops_left_reg  <= pops_left_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg      <= frame_next;
        search_idx_reg <= search_idx_next;
        status_reg     <= status_next;
        out_reg        <= out_next;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    `ICQ_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_reg != ST_IDLE, "accepted transaction did not start")
    `ICQ_ASSERT_IMPL(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= CNT_FULL, "occupancy above queue depth")
    `ICQ_ASSERT_IMPL(a_empty_ptrs, clk, rst_n, state_reg == ST_IDLE && occ_reg == '0, wr_ptr_reg == rd_ptr_reg, "empty queue with split pointers")
    `ICQ_ASSERT_IMPL(a_empty_no_pending, clk, rst_n, occ_reg == '0, !flag_reg, "drain pending on empty queue")
    `ICQ_ASSERT_IMPL(a_pop_nonzero, clk, rst_n, state_reg == ST_POP, pops_left_reg != '0, "pop state with no pops left")

endmodule

// ===== rtl/core/id_coalescing_tx_queue.sv =====
// Coalescing CAN transmit queue.
// Slave channel (s_*) takes one command per transaction: s_tuser selects enqueue
// or drain, s_tdata carries the frame and the drain limits. Master channel (m_*)
// returns the results: an enqueue gives one status transaction, a drain gives
// one transaction per popped frame followed by a summary; m_tlast marks the
// final result of a command and m_tuser gives the result kind.
// Commands are handled one at a time. An enqueue walks the queued entries
// through the entry memory, one read a cycle, oldest first: its status is
// registered after the walk, which ends early on a match. In a drain, each
// pop is one memory read. s_tready is high only between commands. The result
// register lets the next command be taken while the last result still waits.
// A stalled m_tready holds the sequencer at its next result; nothing is
// dropped. Reset empties the queue (pointers and count to zero) at once;
// entry contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// id_coalescing_tx_queue
// transmit queue keeping the newest frame per identifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module id_coalescing_tx_queue #(
    parameter int QUEUE_DEPTH = icq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // frame_id, frame_length, frame_data, drain_amount, fifo_free
    input  logic [icq_pkg::S_TDATA_W-1:0]  s_tdata,
    // cmd
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // enqueue_status, out_id, out_length, out_data, processed, occupancy,
    // drain_pending, zero pad
    output logic [icq_pkg::M_TDATA_W-1:0]  m_tdata,
    // result_kind
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast
);
    import icq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    icq_item_t         item;
    icq_result_t       result;
    logic              ram_wr_en;
    logic [PTR_W-1:0]  ram_wr_addr;
    icq_entry_t        ram_wr_data;
    logic              ram_rd_en;
    logic [PTR_W-1:0]  ram_rd_addr;
    icq_entry_t        ram_rd_data;

    assign item.cmd          = s_tuser[0];
    assign item.frame_id     = s_tdata[28:0];
    assign item.frame_length = s_tdata[32:29];
    assign item.frame_data   = s_tdata[96:33];
    assign item.drain_amount = s_tdata[112:97];
    assign item.fifo_free    = s_tdata[119:113];

    assign m_tdata = {2'b00,
                      result.drain_pending,
                      result.occupancy,
                      result.processed,
                      result.out_data,
                      result.out_length,
                      result.out_id,
                      result.enqueue_status};
    assign m_tuser = result.result_kind;
    assign m_tlast = result.last;

    icq_entry_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    icq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PTR_W       (PTR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_item     (item),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (result),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

endmodule

// ===== test/tb_id_coalescing_tx_queue.sv =====
// ----------------------------------------------------------------------------
// tb_id_coalescing_tx_queue
// self-checking bench for the coalescing CAN transmit queue
//
// Enqueue and drain commands go in on the slave stream. A behavioral copy of
// the queue predicts every result transaction, and the monitor compares each
// one field by field with the oldest prediction. A directed opening covers the
// empty, full, replace and zero-space cases. A random tail follows that swings
// between filling and draining, with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_id_coalescing_tx_queue;

    import icq_pkg::*;

    localparam int DEPTH       = DEFAULT_QUEUE_DEPTH;
    localparam int RANDOM_CMDS = 470;
    localparam int QUIET_LIMIT = 4000;
    localparam int ID_POOL     = 20;

    typedef struct {
        logic                cmd;
        logic [ID_W-1:0]     id;
        logic [LEN_W-1:0]    len;
        logic [DATA_W-1:0]   data;
        logic [AMOUNT_W-1:0] amount;
        logic [FREE_W-1:0]   free;
        bit                  hold;
    } queue_cmd_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = CMD_ENQUEUE;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    queue_cmd_t  pending_cmds[$];
    icq_result_t expected_results[$];
    queue_cmd_t  sent_cmd;

    // shadow of the queue
    logic [ID_W-1:0]   slot_id  [DEPTH];
    logic [LEN_W-1:0]  slot_len [DEPTH];
    logic [DATA_W-1:0] slot_data[DEPTH];
    int unsigned       q_wr;
    int unsigned       q_rd;
    int unsigned       q_count;
    logic              q_pending;

    int error_count  = 0;
    int quiet_cycles = 0;
    int gap_left     = 0;
    int burst_left   = 0;
    int ready_left   = 0;
    int ready_mode   = 0;

    logic [ID_W-1:0] id_pool[ID_POOL];

    id_coalescing_tx_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic push_enqueue(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                                input logic [DATA_W-1:0] data, input bit hold);
        queue_cmd_t c;
        c.cmd    = CMD_ENQUEUE;
        c.id     = id;
        c.len    = len;
        c.data   = data;
        c.amount = AMOUNT_W'($urandom);
        c.free   = FREE_W'($urandom);
        c.hold   = hold;
        pending_cmds.push_back(c);
    endtask

    task automatic push_drain(input logic [AMOUNT_W-1:0] amount,
                              input logic [FREE_W-1:0] free, input bit hold);
        queue_cmd_t c;
        c.cmd    = CMD_DRAIN;
        c.id     = ID_W'($urandom);
        c.len    = LEN_W'($urandom);
        c.data   = {$urandom, $urandom};
        c.amount = amount;
        c.free   = free;
        c.hold   = hold;
        pending_cmds.push_back(c);
    endtask

    task automatic predict_queue_results(input queue_cmd_t c);
        icq_result_t r;
        int unsigned idx;
        int unsigned hit;
        int unsigned pops;
        bit          found;
        r = '0;
        if (c.cmd == CMD_ENQUEUE)
        begin
            found = 1'b0;
            hit   = 0;
            // oldest matching entry wins
            for (int off = 0; off < q_count; off++)
            begin
                idx = (q_rd + off) % DEPTH;
                if (!found && slot_id[idx] == c.id)
                begin
                    found = 1'b1;
                    hit   = idx;
                end
            end
            if (found)
            begin
                slot_len[hit]    = c.len;
                slot_data[hit]   = c.data;
                q_pending        = 1'b1;
                r.enqueue_status = STATUS_REPLACED;
            end
            else if (q_count >= DEPTH)
            begin
                r.enqueue_status = STATUS_REJECTED;
            end
            else
            begin
                slot_id[q_wr]    = c.id;
                slot_len[q_wr]   = c.len;
                slot_data[q_wr]  = c.data;
                q_wr             = (q_wr + 1) % DEPTH;
                q_count++;
                q_pending        = 1'b1;
                r.enqueue_status = STATUS_APPENDED;
            end
            r.result_kind   = KIND_ENQ_STATUS;
            r.occupancy     = FIELD_W'(q_count);
            r.drain_pending = q_pending;
            r.last          = 1'b1;
            expected_results.push_back(r);
        end
        else
        begin
            pops = q_count;
            if (c.amount != 0 && c.amount < pops)
                pops = c.amount;
            if (c.free < pops)
                pops = c.free;
            if (pops > MAX_POPS)
                pops = MAX_POPS;
            q_pending = (q_count - pops) > 0;
            for (int k = 0; k < pops; k++)
            begin
                r               = '0;
                r.result_kind   = KIND_FRAME;
                r.out_id        = slot_id[q_rd];
                r.out_length    = slot_len[q_rd];
                r.out_data      = slot_data[q_rd];
                r.occupancy     = FIELD_W'(q_count - pops);
                r.drain_pending = q_pending;
                expected_results.push_back(r);
                q_rd = (q_rd + 1) % DEPTH;
            end
            q_count         = q_count - pops;
            r               = '0;
            r.result_kind   = KIND_SUMMARY;
            r.processed     = FIELD_W'(pops);
            r.occupancy     = FIELD_W'(q_count);
            r.drain_pending = q_pending;
            r.last          = 1'b1;
            expected_results.push_back(r);
        end
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
        end
    endfunction

    // command driver: bursts separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        logic       next_valid;
        queue_cmd_t c;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= CMD_ENQUEUE;
        end
        else
        begin
            next_valid = s_tvalid && !s_tready;
            if (s_tvalid && s_tready)
                predict_queue_results(sent_cmd);
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_cmds.size() != 0 &&
                         !(pending_cmds[0].hold && expected_results.size() != 0))
                begin
                    c        = pending_cmds.pop_front();
                    sent_cmd = c;
                    s_tdata  <= {c.free, c.amount, c.data, c.len, c.id};
                    s_tuser  <= c.cmd;
                    next_valid = 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // result receiver: stall mode is redrawn at random intervals
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (ready_left == 0)
            begin
                ready_mode = $urandom_range(0, 3);
                ready_left = $urandom_range(20, 300);
            end
            else
                ready_left--;
            case (ready_mode)
                0, 1:    m_tready <= 1'b1;
                2:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        icq_result_t want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: unexpected result, kind %0d data %0h",
                                 $realtime, m_tuser, m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("result_kind", want.result_kind, m_tuser);
                    check_field("enqueue_status", want.enqueue_status, m_tdata[1:0]);
                    check_field("out_id", want.out_id, m_tdata[30:2]);
                    check_field("out_length", want.out_length, m_tdata[34:31]);
                    check_field("out_data", want.out_data, m_tdata[98:35]);
                    check_field("processed", want.processed, m_tdata[103:99]);
                    check_field("occupancy", want.occupancy, m_tdata[108:104]);
                    check_field("drain_pending", want.drain_pending, m_tdata[109]);
                    check_field("last", want.last, m_tlast);
                end
            end
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("id_coalescing_tx_queue regression: fail");
        $finish;
    end

    initial
    begin
        int mode_left;
        int enq_pct;
        int roll;
        logic [ID_W-1:0]     id;
        logic [LEN_W-1:0]    len;
        logic [AMOUNT_W-1:0] amount;
        logic [FREE_W-1:0]   free;

        q_wr      = 0;
        q_rd      = 0;
        q_count   = 0;
        q_pending = 1'b0;
        for (int k = 0; k < DEPTH; k++)
        begin
            slot_id[k]   = '0;
            slot_len[k]  = '0;
            slot_data[k] = '0;
        end
        for (int k = 0; k < ID_POOL; k++)
            id_pool[k] = ID_W'($urandom);
        id_pool[0] = '0;
        id_pool[1] = '1;

        // directed opening
        push_drain(0, 64, 1'b0);
        push_enqueue('0, 4'd0, '0, 1'b0);
        push_enqueue('1, 4'd8, '1, 1'b0);
        push_enqueue('0, 4'd15, 64'h0123_4567_89ab_cdef, 1'b0);
        push_drain(0, 0, 1'b0);
        push_drain(1, 1, 1'b0);
        push_drain(0, 64, 1'b0);
        for (int k = 0; k < DEPTH; k++)
            push_enqueue(ID_W'(29'h1000_0000 + k), LEN_W'(k), {$urandom, $urandom}, 1'b0);
        push_enqueue(29'h0abc_def0, 4'd3, {$urandom, $urandom}, 1'b0);
        push_enqueue(29'h1000_0005, 4'd9, {$urandom, $urandom}, 1'b0);
        push_drain(16'hffff, 64, 1'b0);

        // random tail: segments lean toward filling or draining
        mode_left = 0;
        enq_pct   = 50;
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(20, 60);
                case ($urandom_range(0, 2))
                    0:       enq_pct = 85;
                    1:       enq_pct = 55;
                    default: enq_pct = 30;
                endcase
            end
            else
                mode_left--;
            if ($urandom_range(0, 99) < enq_pct)
            begin
                id  = ($urandom_range(0, 4) == 0) ? ID_W'($urandom)
                                                  : id_pool[$urandom_range(0, ID_POOL - 1)];
                len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(9, 15))
                                                  : LEN_W'($urandom_range(0, 8));
                push_enqueue(id, len, {$urandom, $urandom}, n == 0 || n == 250);
            end
            else
            begin
                roll = $urandom_range(0, 9);
                if (roll < 4)
                    amount = 0;
                else if (roll < 8)
                    amount = AMOUNT_W'($urandom_range(1, 6));
                else
                    amount = AMOUNT_W'($urandom);
                roll = $urandom_range(0, 19);
                if (roll < 3)
                    free = 0;
                else if (roll < 6)
                    free = 64;
                else
                    free = FREE_W'($urandom_range(0, 64));
                push_drain(amount, free, n == 0 || n == 250);
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("id_coalescing_tx_queue regression: pass");
        else
            $display("id_coalescing_tx_queue regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/icq_pkg.sv
rtl/core/icq_entry_ram.sv
rtl/core/icq_ctrl.sv
rtl/core/id_coalescing_tx_queue.sv
test/tb_id_coalescing_tx_queue.sv
